### src/epr_pkg.sv
// Package for the Euler point rotation core: fixed widths, output limits
// and configuration register indexes. Depends on nothing.
package epr_pkg;

   localparam int COEF_WIDTH      = 16;
   localparam int OUT_WIDTH       = 18;
   localparam int OUT_MAX_C       = 131071;
   localparam int OUT_MIN_C       = -131072;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_X = 3'd0,
      CSR_SIN_X = 3'd1,
      CSR_COS_Y = 3'd2,
      CSR_SIN_Y = 3'd3,
      CSR_COS_Z = 3'd4,
      CSR_SIN_Z = 3'd5
   } csr_index_type;

endpackage

### src/epr_rot_stage.sv
// One plane rotation of the point: four products, then round and saturate.
// Two register layers with their own valid bits. Uses epr_pkg.
module epr_rot_stage import epr_pkg::*; #(
   parameter int A_WIDTH    = 16,
   parameter int B_WIDTH    = 16,
   parameter int SIDE_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [A_WIDTH-1:0]    in_a,
   input  logic signed [B_WIDTH-1:0]    in_b,
   input  logic [SIDE_WIDTH-1:0]        in_side,
   input  logic signed [COEF_WIDTH-1:0] coef_cos,
   input  logic signed [COEF_WIDTH-1:0] coef_sin,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [OUT_WIDTH-1:0]  out_u,
   output logic signed [OUT_WIDTH-1:0]  out_v,
   output logic [SIDE_WIDTH-1:0]        out_side
);

   localparam int PA = A_WIDTH + COEF_WIDTH;
   localparam int PB = B_WIDTH + COEF_WIDTH;
   localparam int MW = (A_WIDTH > B_WIDTH) ? A_WIDTH : B_WIDTH;
   localparam int SW = (MW + COEF_WIDTH + 2 > FRAC_BITS + 2) ?
                       MW + COEF_WIDTH + 2 : FRAC_BITS + 2;
   localparam logic signed [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX_C);
   localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN_C);

   logic                  mid_valid_ff, mid_valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  mid_adv, out_adv;
   logic signed [PA-1:0]  pac_ff, pas_ff;
   logic signed [PB-1:0]  pbc_ff, pbs_ff;
   logic [SIDE_WIDTH-1:0] mid_side_ff, out_side_ff;
   logic signed [SW-1:0]  sum_u, sum_v, rnd_u, rnd_v;
   logic signed [OUT_WIDTH-1:0] out_u_ff, out_v_ff;
   logic [1:0]            fill;

   function automatic logic signed [OUT_WIDTH-1:0] sat_out(
      input logic signed [SW-1:0] val);
      logic signed [OUT_WIDTH-1:0] res;
      if (val > SAT_HI) begin
         res = OUT_WIDTH'(SAT_HI);
      end else if (val < SAT_LO) begin
         res = OUT_WIDTH'(SAT_LO);
      end else begin
         res = val[OUT_WIDTH-1:0];
      end
      return res;
   endfunction

   assign out_adv      = !out_valid_ff || out_ready;
   assign mid_adv      = !mid_valid_ff || out_adv;
   assign in_ready     = mid_adv;
   assign mid_valid_in = mid_adv ? in_valid : mid_valid_ff;
   assign out_valid_in = out_adv ? mid_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // multiply layer
   always_ff @(posedge clock) begin
      if (mid_adv && in_valid) begin
         pac_ff      <= PA'(in_a) * PA'(coef_cos);
         pas_ff      <= PA'(in_a) * PA'(coef_sin);
         pbc_ff      <= PB'(in_b) * PB'(coef_cos);
         pbs_ff      <= PB'(in_b) * PB'(coef_sin);
         mid_side_ff <= in_side;
      end
   end

   // sum, round to nearest, saturate
   assign sum_u = SW'(pac_ff) + SW'(pbs_ff) + HALF;
   assign sum_v = SW'(pbc_ff) - SW'(pas_ff) + HALF;
   assign rnd_u = sum_u >>> FRAC_BITS;
   assign rnd_v = sum_v >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (out_adv && mid_valid_ff) begin
         out_u_ff    <= sat_out(rnd_u);
         out_v_ff    <= sat_out(rnd_v);
         out_side_ff <= mid_side_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_u     = out_u_ff;
   assign out_v     = out_v_ff;
   assign out_side  = out_side_ff;

   assign fill = {1'b0, mid_valid_ff} + {1'b0, out_valid_ff};

   a_fill_up: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && !(out_valid_ff && out_ready))
      |=> (fill == $past(fill) + 2'd1))
      else $error("stage lost or duplicated an incoming request");

   a_fill_down: assert property (@(posedge clock) disable iff (reset)
      (!(in_valid && in_ready) && out_valid_ff && out_ready)
      |=> (fill == $past(fill) - 2'd1))
      else $error("stage lost or duplicated a delivered request");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("product layer failed to advance into empty output layer");

endmodule

### src/euler_point_rotation_core.sv
// Euler point rotation core, top level: coefficient registers and three
// rotation stages (Y, then X, then Z). Uses epr_pkg and epr_rot_stage.
//
// Usage:
//  - Request channel (req_valid/req_stall, req_x_in/req_y_in/req_z_in) takes
//    one point per cycle; a point is accepted when req_valid is high and
//    req_stall is low.
//  - Response channel (rsp_valid/rsp_stall, rsp_x_out/rsp_y_out/rsp_z_out)
//    returns the rotated point, rounded to nearest and saturated to 18 bits,
//    one response per request, in order.
//  - Coefficients (cos/sin of each angle, signed Q2.14) are written through
//    csr_write_en/csr_index/csr_data while no request is in flight; indexes
//    beyond the six registers are ignored.
//  - Each of the three rotations has a multiply register layer and a
//    round/saturate register layer.
//  - Throughput is one point per cycle while rsp_stall is low, set by the
//    fully pipelined multipliers (four per rotation).
//  - When rsp_stall is high, points hold in the pipeline and empty layers
//    keep filling; req_stall rises only once every layer is occupied.
//  - Reset empties the pipeline and loads cos = 1.0, sin = 0 for all angles.
module euler_point_rotation_core import epr_pkg::*; #(
   parameter int COORD_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COORD_WIDTH-1:0]    req_x_in,
   input  logic signed [COORD_WIDTH-1:0]    req_y_in,
   input  logic signed [COORD_WIDTH-1:0]    req_z_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [OUT_WIDTH-1:0]      rsp_x_out,
   output logic signed [OUT_WIDTH-1:0]      rsp_y_out,
   output logic signed [OUT_WIDTH-1:0]      rsp_z_out,
   input  logic                             csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [COEF_WIDTH-1:0]            csr_data
);

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

   logic signed [COEF_WIDTH-1:0] cos_x_ff, sin_x_ff;
   logic signed [COEF_WIDTH-1:0] cos_y_ff, sin_y_ff;
   logic signed [COEF_WIDTH-1:0] cos_z_ff, sin_z_ff;

   logic                         y_ready, y_valid, x_ready, x_valid, z_ready;
   logic signed [OUT_WIDTH-1:0]  x1, z1, y2, z2, x3, y3;
   logic [COORD_WIDTH-1:0]       y_carry;
   logic [OUT_WIDTH-1:0]         x1_carry, z2_carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff <= COEF_ONE;
         sin_x_ff <= '0;
         cos_y_ff <= COEF_ONE;
         sin_y_ff <= '0;
         cos_z_ff <= COEF_ONE;
         sin_z_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_COS_X: cos_x_ff <= csr_data;
            CSR_SIN_X: sin_x_ff <= csr_data;
            CSR_COS_Y: cos_y_ff <= csr_data;
            CSR_SIN_Y: sin_y_ff <= csr_data;
            CSR_COS_Z: cos_z_ff <= csr_data;
            CSR_SIN_Z: sin_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // rotate about Y: u = x1, v = z1, carry y
   epr_rot_stage #(
      .A_WIDTH    (COORD_WIDTH),
      .B_WIDTH    (COORD_WIDTH),
      .SIDE_WIDTH (COORD_WIDTH),
      .FRAC_BITS  (COEF_FRAC_BITS)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (y_ready),
      .in_a      (req_x_in),
      .in_b      (req_z_in),
      .in_side   (req_y_in),
      .coef_cos  (cos_y_ff),
      .coef_sin  (sin_y_ff),
      .out_valid (y_valid),
      .out_ready (x_ready),
      .out_u     (x1),
      .out_v     (z1),
      .out_side  (y_carry)
   );

   // rotate about X: u = z2, v = y2, carry x1
   epr_rot_stage #(
      .A_WIDTH    (OUT_WIDTH),
      .B_WIDTH    (COORD_WIDTH),
      .SIDE_WIDTH (OUT_WIDTH),
      .FRAC_BITS  (COEF_FRAC_BITS)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (y_valid),
      .in_ready  (x_ready),
      .in_a      (z1),
      .in_b      (y_carry),
      .in_side   (x1),
      .coef_cos  (cos_x_ff),
      .coef_sin  (sin_x_ff),
      .out_valid (x_valid),
      .out_ready (z_ready),
      .out_u     (z2),
      .out_v     (y2),
      .out_side  (x1_carry)
   );

   // rotate about Z: u = y3, v = x3, carry z2
   epr_rot_stage #(
      .A_WIDTH    (OUT_WIDTH),
      .B_WIDTH    (OUT_WIDTH),
      .SIDE_WIDTH (OUT_WIDTH),
      .FRAC_BITS  (COEF_FRAC_BITS)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .in_ready  (z_ready),
      .in_a      (y2),
      .in_b      (x1_carry),
      .in_side   (z2),
      .coef_cos  (cos_z_ff),
      .coef_sin  (sin_z_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_u     (y3),
      .out_v     (x3),
      .out_side  (z2_carry)
   );

   assign req_stall = !y_ready;
   assign rsp_x_out = x3;
   assign rsp_y_out = y3;
   assign rsp_z_out = z2_carry;

endmodule
